>>> sv/gad_pkg.sv
// gad_pkg: shared constants and types for the gamepad axis deadzone unit
// used by the top level, the stick datapath and the port checker; no dependencies

package gad_pkg;

   localparam int AXIS_BITS_DEFAULT = 16;
   localparam int CSR_ADDR_BITS     = 4;
   localparam int CSR_DATA_BITS     = 32;

   // register word index, taken from paddr[3:2]
   typedef enum logic [1:0] {
      CSR_LEFT_DZ  = 2'd0,
      CSR_RIGHT_DZ = 2'd1,
      CSR_TRIG_DZ  = 2'd2
   } csr_reg_type;

   // cycles from an accepted input beat to its result beat, without stalls
   function automatic int pipe_latency(input int axis_bits);
      return 3 * axis_bits + 23;
   endfunction

endpackage

>>> sv/gamepad_axis_deadzone_unit.sv
// gamepad_axis_deadzone_unit: top level, register port, trigger datapath and beat control
// depends on gad_pkg and gad_stick

// Usage
//   req_*  : one gamepad sample per beat (two sticks signed, two triggers unsigned),
//            taken at an edge with req_valid high and req_stall low
//   rsp_*  : one deadzoned sample per beat, taken with rsp_valid high and rsp_stall low
//   csr_*  : register port, word 0 left stick deadzone, word 1 right stick deadzone,
//            word 2 trigger deadzone; write only while no beat is in flight
// The pipeline has three front stages, an AXIS_BITS+8 stage square root,
// an AXIS_BITS+9 stage divider for the unit direction, a multiply and a rounding
// stage, an AXIS_BITS stage divider by (one - deadzone) and the output register.
// Triggers run a shorter divider and a delay line so that every field of a
// sample arrives in the same beat.
// Throughput is one sample per cycle while no result is held by rsp_stall.
// Reset (synchronous) empties the pipeline and clears all deadzones to zero.
// A stalled result holds the whole pipeline; bubbles in flight do not move
// then, and req_stall is raised in the same cycle, so nothing is lost or repeated.

module gamepad_axis_deadzone_unit #(
   parameter int AXIS_BITS = gad_pkg::AXIS_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [AXIS_BITS-1:0]         req_left_x,
   input  logic signed [AXIS_BITS-1:0]         req_left_y,
   input  logic signed [AXIS_BITS-1:0]         req_right_x,
   input  logic signed [AXIS_BITS-1:0]         req_right_y,
   input  logic        [AXIS_BITS-2:0]         req_left_trigger,
   input  logic        [AXIS_BITS-2:0]         req_right_trigger,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [AXIS_BITS-1:0]         rsp_out_left_x,
   output logic signed [AXIS_BITS-1:0]         rsp_out_left_y,
   output logic signed [AXIS_BITS-1:0]         rsp_out_right_x,
   output logic signed [AXIS_BITS-1:0]         rsp_out_right_y,
   output logic        [AXIS_BITS-2:0]         rsp_out_left_trigger,
   output logic        [AXIS_BITS-2:0]         rsp_out_right_trigger,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [gad_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [gad_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [gad_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready
);

   localparam int N   = AXIS_BITS;
   localparam int LAT = gad_pkg::pipe_latency(AXIS_BITS);
   localparam int TD  = LAT - N - 2;     // trigger delay line length
   localparam int TRW = N + 1;           // trigger divider remainder bits
   localparam int BW  = 2 * N - 1;       // trigger dividend bits
   localparam int AW  = gad_pkg::CSR_ADDR_BITS;
   localparam int DW  = gad_pkg::CSR_DATA_BITS;

   localparam logic [N-1:0] ONE_VAL = {1'b1, {(N-1){1'b0}}};

   // ------------------------------------------------------------------
   // register port: always ready, writes land at the access phase
   // ------------------------------------------------------------------
   logic [N-1:0] left_dz_ff, right_dz_ff, trig_dz_ff;
   logic         csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_dz_ff  <= '0;
         right_dz_ff <= '0;
         trig_dz_ff  <= '0;
      end else if (csr_wr) begin
         unique case (gad_pkg::csr_reg_type'(csr_paddr[AW-1:2]))
            gad_pkg::CSR_LEFT_DZ:  left_dz_ff  <= csr_pwdata[N-1:0];
            gad_pkg::CSR_RIGHT_DZ: right_dz_ff <= csr_pwdata[N-1:0];
            gad_pkg::CSR_TRIG_DZ:  trig_dz_ff  <= csr_pwdata[N-1:0];
            default: ;             // unmapped word, write dropped
         endcase
      end
   end

   always_comb begin
      unique case (gad_pkg::csr_reg_type'(csr_paddr[AW-1:2]))
         gad_pkg::CSR_LEFT_DZ:  csr_prdata = DW'(left_dz_ff);
         gad_pkg::CSR_RIGHT_DZ: csr_prdata = DW'(right_dz_ff);
         gad_pkg::CSR_TRIG_DZ:  csr_prdata = DW'(trig_dz_ff);
         default:               csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // beat control: one shared advance for every stage, valid bits alongside
   // ------------------------------------------------------------------
   logic           adv;
   logic [LAT-1:0] vld_ff;

   // only a held result freezes the pipe
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   // ------------------------------------------------------------------
   // sticks
   // ------------------------------------------------------------------
   gad_stick #(.AXIS_BITS(AXIS_BITS)) u_left_stick (
      .clock (clock),
      .en    (adv),
      .in_x  (req_left_x),
      .in_y  (req_left_y),
      .dz    (left_dz_ff),
      .out_x (rsp_out_left_x),
      .out_y (rsp_out_left_y)
   );

   gad_stick #(.AXIS_BITS(AXIS_BITS)) u_right_stick (
      .clock (clock),
      .en    (adv),
      .in_x  (req_right_x),
      .in_y  (req_right_y),
      .dz    (right_dz_ff),
      .out_x (rsp_out_right_x),
      .out_y (rsp_out_right_y)
   );

   // ------------------------------------------------------------------
   // triggers: rounded ((t - d) * one) / (one - d), capped just below one
   // ------------------------------------------------------------------
   logic [N-1:0] th;
   logic         t_big;
   logic [N-2:0] trig_raw [0:1];
   logic [N-2:0] trig_out [0:1];

   assign th          = ONE_VAL - trig_dz_ff;
   assign t_big       = trig_dz_ff[N-1];
   assign trig_raw[0] = req_left_trigger;
   assign trig_raw[1] = req_right_trigger;

   assign rsp_out_left_trigger  = trig_out[0];
   assign rsp_out_right_trigger = trig_out[1];

   for (genvar g = 0; g < 2; g++) begin : g_trig
      logic [N-1:0]   t_ext, diff;
      logic [BW-1:0]  b_in;
      logic           zero_in;
      logic [TRW-1:0] tr_rem_ff [0:N];
      logic [N-1:0]   tr_low_ff [0:N];
      logic [N-1:0]   tr_q_ff   [0:N];
      logic           tr_z_ff   [0:N];
      logic [TRW-1:0] the;
      logic [N-1:0]   dl_q_ff   [0:TD-1];
      logic           dl_z_ff   [0:TD-1];
      logic [N-2:0]   out_ff;

      assign t_ext   = N'(trig_raw[g]);
      assign diff    = t_ext - trig_dz_ff;
      assign b_in    = (BW'(diff[N-2:0]) << (N-1)) + BW'(th >> 1);
      assign zero_in = t_big | (t_ext <= trig_dz_ff);
      assign the     = TRW'(th);

      always_ff @(posedge clock) begin
         if (adv) begin
            tr_rem_ff[0] <= TRW'(b_in[BW-1:N]);
            tr_low_ff[0] <= b_in[N-1:0];
            tr_q_ff[0]   <= '0;
            tr_z_ff[0]   <= zero_in;
         end
      end

      for (genvar k = 1; k <= N; k++) begin : g_step
         logic [TRW-1:0] r2, rem_in;
         logic           ge;

         always_comb begin
            r2     = {tr_rem_ff[k-1][TRW-2:0], tr_low_ff[k-1][N-1]};
            ge     = (r2 >= the);
            rem_in = ge ? (r2 - the) : r2;
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               tr_rem_ff[k] <= rem_in;
               tr_low_ff[k] <= {tr_low_ff[k-1][N-2:0], 1'b0};
               tr_q_ff[k]   <= {tr_q_ff[k-1][N-2:0], ge};
               tr_z_ff[k]   <= tr_z_ff[k-1];
            end
         end
      end

      // line up with the stick datapath
      always_ff @(posedge clock) begin
         if (adv) begin
            dl_q_ff[0] <= tr_q_ff[N];
            dl_z_ff[0] <= tr_z_ff[N];
            for (int k = 1; k < TD; k++) begin
               dl_q_ff[k] <= dl_q_ff[k-1];
               dl_z_ff[k] <= dl_z_ff[k-1];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            if (dl_z_ff[TD-1]) begin
               out_ff <= '0;
            end else if (dl_q_ff[TD-1][N-1]) begin
               out_ff <= {(N-1){1'b1}};
            end else begin
               out_ff <= dl_q_ff[TD-1][N-2:0];
            end
         end
      end

      assign trig_out[g] = out_ff;
   end

endmodule

>>> sv/gad_stick.sv
// gad_stick: pipelined radial deadzone for one stick (square, root, divide, scale)
// depends on gad_pkg for the default axis width

module gad_stick #(
   parameter int AXIS_BITS = gad_pkg::AXIS_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic signed [AXIS_BITS-1:0] in_x,
   input  logic signed [AXIS_BITS-1:0] in_y,
   input  logic        [AXIS_BITS-1:0] dz,
   output logic signed [AXIS_BITS-1:0] out_x,
   output logic signed [AXIS_BITS-1:0] out_y
);

   localparam int N   = AXIS_BITS;
   localparam int W2  = 2 * N;
   localparam int RB  = N + 8;        // root bits
   localparam int VW  = 2 * N + 16;   // radicand bits
   localparam int SRW = RB + 3;       // root remainder bits
   localparam int QB  = N + 8;        // unit component quotient bits
   localparam int DRW = N + 9;        // divider remainder bits
   localparam int PW  = 2 * N + 16;   // product bits
   localparam int PW1 = PW + 1;
   localparam int FRW = N + 1;        // final divider remainder bits

   localparam logic [N-1:0] ONE_VAL = {1'b1, {(N-1){1'b0}}};
   localparam logic [N-1:0] CAP_VAL = {1'b0, {(N-1){1'b1}}};

   // deadzone terms; the user must keep them steady while beats are in flight, this block does not enforce it
   logic          dz_big;
   logic [N-1:0]  hd;
   logic [RB-1:0] dx;
   logic [RB-1:0] den;
   logic [W2-1:0] dd_ff;

   assign dz_big = dz[N-1];
   assign hd     = ONE_VAL - dz;
   assign dx     = {dz, 8'b0};
   assign den    = {hd, 8'b0};

   always_ff @(posedge clock) begin
      dd_ff <= W2'(dz) * W2'(dz);
   end

   // magnitudes and signs
   logic [N-1:0] raw_x, raw_y;
   logic [N-1:0] s1_mx_ff, s1_my_ff;
   logic         s1_nx_ff, s1_ny_ff, s1_zf_ff;

   assign raw_x = in_x;
   assign raw_y = in_y;

   always_ff @(posedge clock) begin
      if (en) begin
         s1_nx_ff <= raw_x[N-1];
         s1_ny_ff <= raw_y[N-1];
         s1_mx_ff <= raw_x[N-1] ? (N'(0) - raw_x) : raw_x;
         s1_my_ff <= raw_y[N-1] ? (N'(0) - raw_y) : raw_y;
         s1_zf_ff <= dz_big;
      end
   end

   // squares
   logic [W2-1:0] s2_sqx_ff, s2_sqy_ff;
   logic [N-1:0]  s2_mx_ff, s2_my_ff;
   logic          s2_nx_ff, s2_ny_ff, s2_zf_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s2_sqx_ff <= W2'(s1_mx_ff) * W2'(s1_mx_ff);
         s2_sqy_ff <= W2'(s1_my_ff) * W2'(s1_my_ff);
         s2_mx_ff  <= s1_mx_ff;
         s2_my_ff  <= s1_my_ff;
         s2_nx_ff  <= s1_nx_ff;
         s2_ny_ff  <= s1_ny_ff;
         s2_zf_ff  <= s1_zf_ff;
      end
   end

   // square root, one result bit per stage
   logic [VW-1:0]  sq_v_ff    [0:RB];
   logic [SRW-1:0] sq_rem_ff  [0:RB];
   logic [RB-1:0]  sq_root_ff [0:RB];
   logic [N-1:0]   sq_mx_ff   [0:RB];
   logic [N-1:0]   sq_my_ff   [0:RB];
   logic           sq_nx_ff   [0:RB];
   logic           sq_ny_ff   [0:RB];
   logic           sq_skip_ff [0:RB];
   logic [W2-1:0]  sum_sq_in;

   assign sum_sq_in = s2_sqx_ff + s2_sqy_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sq_v_ff[0]    <= {sum_sq_in, 16'b0};
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
         sq_mx_ff[0]   <= s2_mx_ff;
         sq_my_ff[0]   <= s2_my_ff;
         sq_nx_ff[0]   <= s2_nx_ff;
         sq_ny_ff[0]   <= s2_ny_ff;
         // inside the deadzone circle, tested on the exact square
         sq_skip_ff[0] <= s2_zf_ff | (sum_sq_in <= dd_ff);
      end
   end

   for (genvar j = 1; j <= RB; j++) begin : g_sqrt
      logic [SRW-1:0] r2, trial, rem_in;
      logic           ge;

      always_comb begin
         r2     = {sq_rem_ff[j-1][SRW-3:0], sq_v_ff[j-1][VW-1:VW-2]};
         trial  = SRW'({sq_root_ff[j-1], 2'b01});
         ge     = (r2 >= trial);
         rem_in = ge ? (r2 - trial) : r2;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sq_rem_ff[j]  <= rem_in;
            sq_root_ff[j] <= {sq_root_ff[j-1][RB-2:0], ge};
            sq_v_ff[j]    <= {sq_v_ff[j-1][VW-3:0], 2'b00};
            sq_mx_ff[j]   <= sq_mx_ff[j-1];
            sq_my_ff[j]   <= sq_my_ff[j-1];
            sq_nx_ff[j]   <= sq_nx_ff[j-1];
            sq_ny_ff[j]   <= sq_ny_ff[j-1];
            sq_skip_ff[j] <= sq_skip_ff[j-1];
         end
      end
   end

   // unit direction: |c| * 2^(N+15) / length, one quotient bit per stage
   logic [RB-1:0]  dv_lx_ff   [0:QB];
   logic [RB-1:0]  dv_sn_ff   [0:QB];
   logic [DRW-1:0] dv_remx_ff [0:QB];
   logic [DRW-1:0] dv_remy_ff [0:QB];
   logic [QB-1:0]  dv_qx_ff   [0:QB];
   logic [QB-1:0]  dv_qy_ff   [0:QB];
   logic           dv_nx_ff   [0:QB];
   logic           dv_ny_ff   [0:QB];
   logic           dv_skip_ff [0:QB];
   logic [RB-1:0]  lx_fin, num_in, sn_in;

   assign lx_fin = sq_root_ff[RB];
   assign num_in = lx_fin - dx;
   assign sn_in  = (num_in < den) ? num_in : den;

   always_ff @(posedge clock) begin
      if (en) begin
         dv_lx_ff[0]   <= lx_fin;
         dv_sn_ff[0]   <= sn_in;
         dv_remx_ff[0] <= DRW'(sq_mx_ff[RB]) << 7;
         dv_remy_ff[0] <= DRW'(sq_my_ff[RB]) << 7;
         dv_qx_ff[0]   <= '0;
         dv_qy_ff[0]   <= '0;
         dv_nx_ff[0]   <= sq_nx_ff[RB];
         dv_ny_ff[0]   <= sq_ny_ff[RB];
         // truncated root no greater than the deadzone
         dv_skip_ff[0] <= sq_skip_ff[RB] | (lx_fin <= dx);
      end
   end

   for (genvar j = 1; j <= QB; j++) begin : g_unit
      logic [DRW-1:0] r2x, r2y, lxe, remx_in, remy_in;
      logic           gex, gey;

      always_comb begin
         lxe     = DRW'(dv_lx_ff[j-1]);
         r2x     = {dv_remx_ff[j-1][DRW-2:0], 1'b0};
         r2y     = {dv_remy_ff[j-1][DRW-2:0], 1'b0};
         gex     = (r2x >= lxe);
         gey     = (r2y >= lxe);
         remx_in = gex ? (r2x - lxe) : r2x;
         remy_in = gey ? (r2y - lxe) : r2y;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_lx_ff[j]   <= dv_lx_ff[j-1];
            dv_sn_ff[j]   <= dv_sn_ff[j-1];
            dv_remx_ff[j] <= remx_in;
            dv_remy_ff[j] <= remy_in;
            dv_qx_ff[j]   <= {dv_qx_ff[j-1][QB-2:0], gex};
            dv_qy_ff[j]   <= {dv_qy_ff[j-1][QB-2:0], gey};
            dv_nx_ff[j]   <= dv_nx_ff[j-1];
            dv_ny_ff[j]   <= dv_ny_ff[j-1];
            dv_skip_ff[j] <= dv_skip_ff[j-1];
         end
      end
   end

   // scale by the capped stretch
   logic [PW-1:0] mu_px_ff, mu_py_ff;
   logic          mu_nx_ff, mu_ny_ff, mu_skip_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         mu_px_ff   <= PW'(dv_qx_ff[QB]) * PW'(dv_sn_ff[QB]);
         mu_py_ff   <= PW'(dv_qy_ff[QB]) * PW'(dv_sn_ff[QB]);
         mu_nx_ff   <= dv_nx_ff[QB];
         mu_ny_ff   <= dv_ny_ff[QB];
         mu_skip_ff <= dv_skip_ff[QB];
      end
   end

   // round half up, drop 16 bits, then divide by (one - deadzone)
   logic [FRW-1:0] fd_remx_ff [0:N];
   logic [FRW-1:0] fd_remy_ff [0:N];
   logic [N-1:0]   fd_lowx_ff [0:N];
   logic [N-1:0]   fd_lowy_ff [0:N];
   logic [N-1:0]   fd_qx_ff   [0:N];
   logic [N-1:0]   fd_qy_ff   [0:N];
   logic           fd_nx_ff   [0:N];
   logic           fd_ny_ff   [0:N];
   logic           fd_skip_ff [0:N];
   logic [PW1-1:0] ax_sum, ay_sum;
   logic [FRW-1:0] he;

   assign ax_sum = PW1'(mu_px_ff) + PW1'({hd, 15'b0});
   assign ay_sum = PW1'(mu_py_ff) + PW1'({hd, 15'b0});
   assign he     = FRW'(hd);

   always_ff @(posedge clock) begin
      if (en) begin
         fd_remx_ff[0] <= ax_sum[PW:16+N];
         fd_remy_ff[0] <= ay_sum[PW:16+N];
         fd_lowx_ff[0] <= ax_sum[16+N-1:16];
         fd_lowy_ff[0] <= ay_sum[16+N-1:16];
         fd_qx_ff[0]   <= '0;
         fd_qy_ff[0]   <= '0;
         fd_nx_ff[0]   <= mu_nx_ff;
         fd_ny_ff[0]   <= mu_ny_ff;
         fd_skip_ff[0] <= mu_skip_ff;
      end
   end

   for (genvar j = 1; j <= N; j++) begin : g_scale
      logic [FRW-1:0] r2x, r2y, remx_in, remy_in;
      logic           gex, gey;

      always_comb begin
         r2x     = {fd_remx_ff[j-1][FRW-2:0], fd_lowx_ff[j-1][N-1]};
         r2y     = {fd_remy_ff[j-1][FRW-2:0], fd_lowy_ff[j-1][N-1]};
         gex     = (r2x >= he);
         gey     = (r2y >= he);
         remx_in = gex ? (r2x - he) : r2x;
         remy_in = gey ? (r2y - he) : r2y;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            fd_remx_ff[j] <= remx_in;
            fd_remy_ff[j] <= remy_in;
            fd_lowx_ff[j] <= {fd_lowx_ff[j-1][N-2:0], 1'b0};
            fd_lowy_ff[j] <= {fd_lowy_ff[j-1][N-2:0], 1'b0};
            fd_qx_ff[j]   <= {fd_qx_ff[j-1][N-2:0], gex};
            fd_qy_ff[j]   <= {fd_qy_ff[j-1][N-2:0], gey};
            fd_nx_ff[j]   <= fd_nx_ff[j-1];
            fd_ny_ff[j]   <= fd_ny_ff[j-1];
            fd_skip_ff[j] <= fd_skip_ff[j-1];
         end
      end
   end

   // saturate, restore sign, force zero inside the deadzone
   logic [N-1:0] magx, magy;
   logic [N-1:0] out_x_ff, out_y_ff;

   assign magx = fd_qx_ff[N][N-1] ? CAP_VAL : fd_qx_ff[N];
   assign magy = fd_qy_ff[N][N-1] ? CAP_VAL : fd_qy_ff[N];

   always_ff @(posedge clock) begin
      if (en) begin
         out_x_ff <= fd_skip_ff[N] ? '0 : (fd_nx_ff[N] ? (N'(0) - magx) : magx);
         out_y_ff <= fd_skip_ff[N] ? '0 : (fd_ny_ff[N] ? (N'(0) - magy) : magy);
      end
   end

   assign out_x = out_x_ff;
   assign out_y = out_y_ff;

endmodule

>>> sv/gad_checker.sv
// gad_checker: port-level assertions for the gamepad axis deadzone unit
// depends on gad_pkg; bound to gamepad_axis_deadzone_unit at the end of this file

module gad_checker #(
   parameter int AXIS_BITS = gad_pkg::AXIS_BITS_DEFAULT
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic signed [AXIS_BITS-1:0] rsp_out_left_x,
   input logic signed [AXIS_BITS-1:0] rsp_out_left_y,
   input logic signed [AXIS_BITS-1:0] rsp_out_right_x,
   input logic signed [AXIS_BITS-1:0] rsp_out_right_y,
   input logic        [AXIS_BITS-2:0] rsp_out_left_trigger,
   input logic        [AXIS_BITS-2:0] rsp_out_right_trigger
);

   localparam logic [AXIS_BITS-1:0] MIN_VAL = {1'b1, {(AXIS_BITS-1){1'b0}}};

   // reset empties the pipe
   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat present right after reset");

   // input back-pressure only from a held result
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without output back-pressure");

   // stick outputs saturate symmetrically
   a_no_neg_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_left_x != MIN_VAL) && (rsp_out_left_y != MIN_VAL)
                 && (rsp_out_right_x != MIN_VAL) && (rsp_out_right_y != MIN_VAL))
      else $error("stick output reached negative full scale");

   // held result beat stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_out_left_x)
         && $stable(rsp_out_left_y) && $stable(rsp_out_right_x)
         && $stable(rsp_out_right_y) && $stable(rsp_out_left_trigger)
         && $stable(rsp_out_right_trigger))
      else $error("stalled result beat changed");

endmodule

bind gamepad_axis_deadzone_unit gad_checker #(.AXIS_BITS(AXIS_BITS)) u_gad_checker (.*);

>>> bench/gamepad_axis_deadzone_checker.sv
`timescale 1ns / 1ps
// gamepad_axis_deadzone_checker: watches the sample and result channels of the deadzone unit,
// predicts each result and compares it; uses gad_pkg for widths and register indices

module gamepad_axis_deadzone_checker #(
   parameter int AXIS_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic signed [AXIS_BITS-1:0] req_left_x,
   input  logic signed [AXIS_BITS-1:0] req_left_y,
   input  logic signed [AXIS_BITS-1:0] req_right_x,
   input  logic signed [AXIS_BITS-1:0] req_right_y,
   input  logic        [AXIS_BITS-2:0] req_left_trigger,
   input  logic        [AXIS_BITS-2:0] req_right_trigger,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic signed [AXIS_BITS-1:0] rsp_out_left_x,
   input  logic signed [AXIS_BITS-1:0] rsp_out_left_y,
   input  logic signed [AXIS_BITS-1:0] rsp_out_right_x,
   input  logic signed [AXIS_BITS-1:0] rsp_out_right_y,
   input  logic        [AXIS_BITS-2:0] rsp_out_left_trigger,
   input  logic        [AXIS_BITS-2:0] rsp_out_right_trigger,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic                        csr_pready,
   input  logic [gad_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [gad_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output int                          fail_count,
   output int                          pending_count
);

   localparam longint unsigned UNITY = 64'd1 << (AXIS_BITS - 1);

   typedef struct packed {
      logic [AXIS_BITS-1:0] lx, ly, rx, ry;
      logic [AXIS_BITS-2:0] lt, rt;
   } pad_sample_type;

   logic [AXIS_BITS-1:0] left_dz, right_dz, trig_dz;
   pad_sample_type deadzoned_q[$];

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic logic [AXIS_BITS-1:0] signed_out(longint unsigned mag, bit neg);
      logic [AXIS_BITS-1:0] m;
      if (mag > UNITY - 1) mag = UNITY - 1;
      m = mag[AXIS_BITS-1:0];
      return neg ? -m : m;
   endfunction

   task automatic radial_deadzone(input logic [AXIS_BITS-1:0] cx, input logic [AXIS_BITS-1:0] cy,
                                  input logic [AXIS_BITS-1:0] dzr,
                                  output logic [AXIS_BITS-1:0] ox,
                                  output logic [AXIS_BITS-1:0] oy);
      longint unsigned mx, my, sq, len, dzs, num, den, scl, den8, ux, uy, dz;
      bit nx, ny;
      ox = '0;
      oy = '0;
      dz = 64'(dzr);
      nx = cx[AXIS_BITS-1];
      ny = cy[AXIS_BITS-1];
      mx = nx ? (64'd1 << AXIS_BITS) - 64'(cx) : 64'(cx);
      my = ny ? (64'd1 << AXIS_BITS) - 64'(cy) : 64'(cy);
      if (dz >= UNITY) return;
      sq = mx * mx + my * my;
      if (sq <= dz * dz) return;
      len = int_sqrt(sq << 16);
      dzs = dz << 8;
      if (len <= dzs) return;
      num = len - dzs;
      den = (UNITY - dz) << 8;
      scl = num < den ? num : den;
      den8 = den << 8;
      ux = (mx << (AXIS_BITS + 15)) / len;
      uy = (my << (AXIS_BITS + 15)) / len;
      ox = signed_out((ux * scl + (den8 >> 1)) / den8, nx);
      oy = signed_out((uy * scl + (den8 >> 1)) / den8, ny);
   endtask

   function automatic logic [AXIS_BITS-2:0] trigger_deadzone(logic [AXIS_BITS-2:0] t,
                                                            logic [AXIS_BITS-1:0] dzr);
      longint unsigned den, r, tv, dz;
      tv = 64'(t);
      dz = 64'(dzr);
      if (dz >= UNITY || tv <= dz) return '0;
      den = UNITY - dz;
      r = ((tv - dz) * UNITY + (den >> 1)) / den;
      if (r > UNITY - 1) r = UNITY - 1;
      return r[AXIS_BITS-2:0];
   endfunction

   always @(posedge clock) begin
      pad_sample_type exp_s, got;
      if (reset) begin
         left_dz  <= '0;
         right_dz <= '0;
         trig_dz  <= '0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               gad_pkg::CSR_LEFT_DZ: begin
                  left_dz <= csr_pwdata[AXIS_BITS-1:0];
               end
               gad_pkg::CSR_RIGHT_DZ: begin
                  right_dz <= csr_pwdata[AXIS_BITS-1:0];
               end
               gad_pkg::CSR_TRIG_DZ: begin
                  trig_dz <= csr_pwdata[AXIS_BITS-1:0];
               end
               default: begin
               end
            endcase
         end
         if (req_valid && !req_stall) begin
            radial_deadzone(req_left_x, req_left_y, left_dz, exp_s.lx, exp_s.ly);
            radial_deadzone(req_right_x, req_right_y, right_dz, exp_s.rx, exp_s.ry);
            exp_s.lt = trigger_deadzone(req_left_trigger, trig_dz);
            exp_s.rt = trigger_deadzone(req_right_trigger, trig_dz);
            deadzoned_q.push_back(exp_s);
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_out_left_x, rsp_out_left_y, rsp_out_right_x, rsp_out_right_y,
                   rsp_out_left_trigger, rsp_out_right_trigger};
            if (deadzoned_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("result beat with nothing expected: %h", got);
            end else begin
               exp_s = deadzoned_q.pop_front();
               if (got !== exp_s) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("mismatch exp/got lx %0d/%0d ly %0d/%0d rx %0d/%0d ry %0d/%0d",
                        $signed(exp_s.lx), rsp_out_left_x, $signed(exp_s.ly), rsp_out_left_y,
                        $signed(exp_s.rx), rsp_out_right_x, $signed(exp_s.ry), rsp_out_right_y);
                     $display("   triggers exp/got lt %0d/%0d rt %0d/%0d",
                        exp_s.lt, rsp_out_left_trigger, exp_s.rt, rsp_out_right_trigger);
                  end
               end
            end
         end
      end
      pending_count = deadzoned_q.size();
   end

   initial begin
      fail_count = 0;
      pending_count = 0;
   end
endmodule

>>> bench/gamepad_axis_deadzone_unit_tb.sv
`timescale 1ns / 1ps
// gamepad_axis_deadzone_unit_tb: stimulus and verdict for the deadzone unit
// depends on gad_pkg, gamepad_axis_deadzone_unit and gamepad_axis_deadzone_checker

module gamepad_axis_deadzone_unit_tb;

   localparam int AB      = gad_pkg::AXIS_BITS_DEFAULT;
   localparam int TW      = AB - 1;
   localparam int LAT     = gad_pkg::pipe_latency(AB);
   localparam int LIMIT   = 400000;
   localparam int N_RAND  = 1430;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [AB-1:0] req_left_x = '0, req_left_y = '0, req_right_x = '0, req_right_y = '0;
   logic [AB-2:0] req_left_trigger = '0, req_right_trigger = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [AB-1:0] rsp_out_left_x, rsp_out_left_y, rsp_out_right_x, rsp_out_right_y;
   logic [AB-2:0] rsp_out_left_trigger, rsp_out_right_trigger;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [gad_pkg::CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [gad_pkg::CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [gad_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   int fail_count, pending_count;
   int cycle_count = 0;
   bit calm_tail = 1'b0;   // last part of the run has no idling

   always #5 clock = ~clock;

   gamepad_axis_deadzone_unit #(.AXIS_BITS(AB)) uut (.*);
   gamepad_axis_deadzone_checker #(.AXIS_BITS(AB)) checker_i (.*);

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // result side back-pressure in bursts
   initial begin
      int n;
      @(negedge clock);
      while (1) begin
         n = $urandom_range(1, 12);
         if (!calm_tail && $urandom_range(0, 2) == 0) rsp_stall <= 1'b1;
         else rsp_stall <= 1'b0;
         repeat (n) @(negedge clock);
      end
   end

   // register write: setup cycle then access cycle
   task automatic csr_write(input gad_pkg::csr_reg_type idx, input logic [AB-1:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= gad_pkg::CSR_ADDR_BITS'(idx) << 2;
      csr_pwdata  <= gad_pkg::CSR_DATA_BITS'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // one sample beat; held until accepted
   task automatic send_sample(input logic [AB-1:0] lx, ly, rx, ry, input logic [AB-2:0] lt, rt);
      req_valid <= 1'b1;
      req_left_x <= lx;
      req_left_y <= ly;
      req_right_x <= rx;
      req_right_y <= ry;
      req_left_trigger <= lt;
      req_right_trigger <= rt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic sender_gap();
      if (!calm_tail && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic random_sample();
      logic [AB-1:0] a, b, c, d;
      case ($urandom_range(0, 4))
         0: begin   // full range
            a = AB'($urandom); b = AB'($urandom); c = AB'($urandom); d = AB'($urandom);
         end
         1: begin   // near centre, around typical deadzones
            a = AB'($urandom_range(0, 4000) - 2000); b = AB'($urandom_range(0, 4000) - 2000);
            c = AB'($urandom_range(0, 12000) - 6000); d = AB'($urandom_range(0, 12000) - 6000);
         end
         2: begin   // extremes of the square
            a = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
            b = $urandom_range(0, 1) ? 16'h8000 : AB'($urandom);
            c = AB'($urandom); d = $urandom_range(0, 1) ? 16'h8001 : 16'h7fff;
         end
         default: begin
            a = AB'($urandom_range(0, 40000) - 20000); b = AB'($urandom_range(0, 40000) - 20000);
            c = AB'($urandom_range(0, 40000) - 20000); d = AB'($urandom_range(0, 40000) - 20000);
         end
      endcase
      send_sample(a, b, c, d, TW'($urandom), TW'($urandom));
   endtask

   initial begin
      logic [AB-1:0] dz_set[6];
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: zero deadzones, extremes and full-scale negatives
      send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 15'h0000, 15'h0000);
      send_sample(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 15'h7fff, 15'h7fff);
      send_sample(16'h8000, 16'h0000, 16'h0000, 16'h8000, 15'h0001, 15'h4000);
      send_sample(16'h7fff, 16'h0000, 16'hffff, 16'h0001, 15'h7ffe, 15'h0000);
      drain();

      // directed: typical deadzones, lengths around and on the boundary
      csr_write(gad_pkg::CSR_LEFT_DZ, 16'd8000);
      csr_write(gad_pkg::CSR_RIGHT_DZ, 16'd3000);
      csr_write(gad_pkg::CSR_TRIG_DZ, 16'd4000);
      send_sample(16'd8000, 16'd0, 16'd1800, 16'd2400, 15'd4000, 15'd4001);
      send_sample(16'd8001, 16'd0, -16'sd1800, -16'sd2401, 15'd3999, 15'h7fff);
      send_sample(16'd4800, 16'd6400, 16'd3001, 16'd0, 15'd0, 15'd20000);
      send_sample(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 15'h7fff, 15'd10000);
      send_sample(-16'sd5657, 16'd5657, 16'd0, -16'sd3000, 15'd4002, 15'd30000);
      drain();

      // directed: deadzone of one and above forces zero, register beyond the list
      csr_write(gad_pkg::CSR_LEFT_DZ, 16'h8000);
      csr_write(gad_pkg::CSR_RIGHT_DZ, 16'hffff);
      csr_write(gad_pkg::CSR_TRIG_DZ, 16'h8000);
      csr_write(gad_pkg::csr_reg_type'(2'd3), 16'h1234);
      send_sample(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 15'h7fff, 15'h7fff);
      send_sample(16'h1000, 16'h0000, 16'h0000, 16'h1000, 15'h1234, 15'h0001);
      drain();
      csr_write(gad_pkg::CSR_LEFT_DZ, 16'h7fff);
      csr_write(gad_pkg::CSR_RIGHT_DZ, 16'h7ffe);
      csr_write(gad_pkg::CSR_TRIG_DZ, 16'h7fff);
      send_sample(16'h7fff, 16'h7fff, 16'h8000, 16'h0000, 15'h7fff, 15'h7ffe);
      send_sample(16'h8000, 16'h8000, 16'h7fff, 16'h0000, 15'h7fff, 15'h7fff);
      drain();

      // random phases across several deadzone settings
      dz_set = '{16'd0, 16'd1, 16'd6000, 16'd16384, 16'h7fff, 16'h8000};
      for (int ph = 0; ph < 8; ph++) begin
         csr_write(gad_pkg::CSR_LEFT_DZ,
                   ph < 6 ? dz_set[ph] : 16'($urandom_range(0, 32768)));
         csr_write(gad_pkg::CSR_RIGHT_DZ, ph < 6 ? dz_set[5 - ph] : 16'($urandom));
         csr_write(gad_pkg::CSR_TRIG_DZ, 16'($urandom_range(0, 32768)));
         if (ph == 7) calm_tail = 1'b1;
         for (int i = 0; i < N_RAND / 8; i++) begin
            sender_gap();
            random_sample();
         end
         drain();
      end

      repeat (LAT + 20) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

>>> filelist.f
sv/gad_pkg.sv
sv/gad_stick.sv
sv/gamepad_axis_deadzone_unit.sv
sv/gad_checker.sv
bench/gamepad_axis_deadzone_checker.sv
bench/gamepad_axis_deadzone_unit_tb.sv
